>>> rtl/scrs_pkg.sv
// Shared types, constants and helpers for the SPI command register slave.
package scrs_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_CODE  = 2'd0,
    REG_READ_CODE  = 2'd1,
    REG_WRITE_CODE = 2'd2,
    REG_ERROR_CODE = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    REPLY_NONE  = 2'd0,
    REPLY_ERROR = 2'd1,
    REPLY_DATA  = 2'd2
  } reply_sel_e;

  typedef struct packed {
    logic       capture;
    logic       finish;
    logic       latch_addr;
    logic       store_wr;
    logic       sync_err;
    reply_sel_e reply;
  } dp_cmd_t;

  typedef struct packed {
    logic match_sync;
    logic match_read;
    logic match_write;
    logic out_free;
  } dp_status_t;

  function automatic logic addr_ok(logic [BYTE_W-1:0] addr);
    addr_ok = ({1'b0, addr} < (BYTE_W + 1)'(STORE_DEPTH));
  endfunction

endpackage

>>> rtl/scrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module scrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/scrs_ctrl.sv
// Controller: transaction handshake sequencing and the command/address/data phase machine.
module scrs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  scrs_pkg::dp_status_t status_i,
  output scrs_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   pend_write_q, pend_write_d;

  always_comb begin
    cmd_o        = '0;
    cmd_o.reply  = scrs_pkg::REPLY_NONE;
    state_d      = state_q;
    phase_d      = phase_q;
    pend_write_d = pend_write_q;
    in_ready_o   = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
          unique case (phase_q)
            PH_CMD: begin
              priority if (status_i.match_sync) begin
                phase_d = PH_CMD;
              end else if (status_i.match_read) begin
                pend_write_d = 1'b0;
                phase_d      = PH_ADDR;
              end else if (status_i.match_write) begin
                pend_write_d = 1'b1;
                phase_d      = PH_ADDR;
              end else begin
                cmd_o.reply    = scrs_pkg::REPLY_ERROR;
                cmd_o.sync_err = 1'b1;
                phase_d        = PH_CMD;
              end
            end
            PH_ADDR: begin
              cmd_o.latch_addr = 1'b1;
              phase_d          = PH_DATA;
              if (!pend_write_q) begin
                cmd_o.reply = scrs_pkg::REPLY_DATA;
              end
            end
            default: begin
              cmd_o.store_wr = pend_write_q;
              phase_d        = PH_CMD;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_CMD;
      pend_write_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      pend_write_q <= pend_write_d;
    end
  end

endmodule

>>> rtl/scrs_dp.sv
// Datapath: configuration registers, byte store with valid bits, and the result register.
module scrs_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [scrs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [scrs_pkg::BYTE_W-1:0]          cfg_data_i,
  input  logic [scrs_pkg::BYTE_W-1:0]          rx_byte_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [scrs_pkg::BYTE_W-1:0]          reply_byte_o,
  output logic                                 reply_loaded_o,
  output logic                                 sync_error_o,
  output logic [scrs_pkg::BYTE_W-1:0]          led_pattern_o,
  input  scrs_pkg::dp_cmd_t                    cmd_i,
  output scrs_pkg::dp_status_t                 status_o
);

  logic [scrs_pkg::BYTE_W-1:0]   sync_code_q, read_code_q, write_code_q, error_code_q;
  logic [scrs_pkg::BYTE_W-1:0]   byte_q;
  logic [scrs_pkg::BYTE_W-1:0]   held_addr_q;
  logic [scrs_pkg::BYTE_W-1:0]   led_q;
  logic [scrs_pkg::BYTE_W-1:0]   rdata;
  logic [scrs_pkg::BYTE_W-1:0]   reply_d;
  logic [scrs_pkg::STORE_DEPTH-1:0] valid_q;
  logic                          rd_ok_q;
  logic                          out_valid_q;
  logic [scrs_pkg::BYTE_W-1:0]   reply_q;
  logic                          loaded_q, err_q;
  logic                          ram_we;
  logic [scrs_pkg::STORE_AW-1:0] raddr, waddr;

  assign raddr  = rx_byte_i[scrs_pkg::STORE_AW-1:0];
  assign waddr  = held_addr_q[scrs_pkg::STORE_AW-1:0];
  assign ram_we = cmd_i.store_wr && scrs_pkg::addr_ok(held_addr_q);

  scrs_ram #(
    .Width(scrs_pkg::BYTE_W),
    .Depth(scrs_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(byte_q),
    .re_i   (cmd_i.capture),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_code_q  <= 8'd0;
      read_code_q  <= 8'd1;
      write_code_q <= 8'd2;
      error_code_q <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (scrs_pkg::reg_idx_e'(cfg_index_i))
        scrs_pkg::REG_SYNC_CODE:  sync_code_q  <= cfg_data_i;
        scrs_pkg::REG_READ_CODE:  read_code_q  <= cfg_data_i;
        scrs_pkg::REG_WRITE_CODE: write_code_q <= cfg_data_i;
        scrs_pkg::REG_ERROR_CODE: error_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      led_q       <= '0;
      held_addr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_q[waddr] <= 1'b1;
        if (held_addr_q == '0) begin
          led_q <= byte_q;
        end
      end
      if (cmd_i.latch_addr) begin
        held_addr_q <= byte_q;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q  <= rx_byte_i;
      rd_ok_q <= scrs_pkg::addr_ok(rx_byte_i) && valid_q[raddr];
    end
    if (cmd_i.finish) begin
      reply_q  <= reply_d;
      loaded_q <= (cmd_i.reply != scrs_pkg::REPLY_NONE);
      err_q    <= cmd_i.sync_err;
    end
  end

  always_comb begin
    unique case (cmd_i.reply)
      scrs_pkg::REPLY_ERROR: reply_d = error_code_q;
      scrs_pkg::REPLY_DATA:  reply_d = rd_ok_q ? rdata : '0;
      default:               reply_d = '0;
    endcase
  end

  assign status_o.match_sync  = (byte_q == sync_code_q);
  assign status_o.match_read  = (byte_q == read_code_q);
  assign status_o.match_write = (byte_q == write_code_q);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign reply_byte_o   = reply_q;
  assign reply_loaded_o = loaded_q;
  assign sync_error_o   = err_q;
  assign led_pattern_o  = led_q;

endmodule

>>> rtl/spi_command_register_slave_core.sv
// Top level of the SPI command register slave: controller plus datapath.
//
//   Channel   Signals                                   Direction
//   input     in_valid_i / in_ready_o, rx_byte_i        in
//   output    out_valid_o / out_ready_i, reply_byte_o,  out
//             reply_loaded_o, sync_error_o, led_pattern_o
//   config    cfg_we_i, cfg_index_i, cfg_data_i         in
//
// A transaction accepts the byte and starts the store read in ST_IDLE, then
// decides the phase step and loads the result register in ST_EXEC.
// The registered read of the byte store is why these steps are in separate states.
// A new byte is accepted while an earlier result still waits in the output register.
// A stalled output holds ST_EXEC until the result register frees up.
// Reset clears the store's valid bits at once; no clearing pass is needed.
module spi_command_register_slave_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [scrs_pkg::BYTE_W-1:0]    rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [scrs_pkg::BYTE_W-1:0]    reply_byte_o,
  output logic                           reply_loaded_o,
  output logic                           sync_error_o,
  output logic [scrs_pkg::BYTE_W-1:0]    led_pattern_o,
  input  logic                           cfg_we_i,
  input  logic [scrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [scrs_pkg::BYTE_W-1:0]    cfg_data_i
);

  scrs_pkg::dp_cmd_t    cmd;
  scrs_pkg::dp_status_t status;

  scrs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  scrs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .rx_byte_i     (rx_byte_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .reply_byte_o  (reply_byte_o),
    .reply_loaded_o(reply_loaded_o),
    .sync_error_o  (sync_error_o),
    .led_pattern_o (led_pattern_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

>>> rtl/scrs_checker.sv
// Port-level assertions for the SPI command register slave and their bind.
module scrs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [scrs_pkg::BYTE_W-1:0] reply_byte_o,
  input logic                        reply_loaded_o,
  input logic                        sync_error_o
);

  a_err_loads_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sync_error_o |-> reply_loaded_o)
    else $error("sync error without a loaded reply");

  a_unloaded_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reply_loaded_o |-> reply_byte_o == '0)
    else $error("reply byte nonzero without a loaded reply");

  a_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on two consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(reply_byte_o))
    else $error("stalled result changed");

endmodule

bind spi_command_register_slave_core scrs_checker u_scrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .reply_byte_o  (reply_byte_o),
  .reply_loaded_o(reply_loaded_o),
  .sync_error_o  (sync_error_o)
);
